### rtl/core/ftacc_pkg.sv
`default_nettype none

package ftacc_pkg;

   // Operation codes carried by the request op field.
   typedef enum logic [1:0] {
      OP_UPDATE     = 2'd0,
      OP_ADVANCE    = 2'd1,
      OP_RESET_IDLE = 2'd2,
      OP_RESET_AT   = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TICK_LENGTH = 1'b0,
      CSR_TICK_CAP    = 1'b1
   } csr_index_type;

   localparam int unsigned OP_W       = 2;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned CAP_W      = 8;
   localparam int unsigned ALPHA_W    = 16;
   localparam int unsigned TOTAL_W    = 48;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned QUOT_STEPS = 64;
   localparam int unsigned STEP_W     = $clog2(QUOT_STEPS);

   localparam logic [TICK_W-1:0] TICK_RESET = 32'd16666667;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 8'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SUM,
      ST_QUOT,
      ST_FSTART,
      ST_FRAC,
      ST_PUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic prep;
      logic bank;
      logic qstep;
      logic fstart;
      logic fstep;
      logic push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic quick;
      logic q_last;
      logic f_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/ftacc_if.sv
`default_nettype none

interface ftacc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftacc_pkg::OP_W-1:0]    op;
   logic [ftacc_pkg::VALUE_W-1:0] value_ns;

   modport source (output valid, output op, output value_ns, input ready);
   modport sink   (input valid, input op, input value_ns, output ready);
endinterface

interface ftacc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ftacc_pkg::CAP_W-1:0]   ticks_granted;
   logic                        capped;
   logic [ftacc_pkg::ALPHA_W-1:0] alpha_q16;
   logic [ftacc_pkg::TOTAL_W-1:0] tick_total;

   modport source (output valid, output ticks_granted, output capped,
                   output alpha_q16, output tick_total, input ready);
   modport sink   (input valid, input ticks_granted, input capped,
                   input alpha_q16, input tick_total, output ready);
endinterface

interface ftacc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ftacc_pkg::CSR_IDX_W-1:0]  index;
   logic [ftacc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/fixed_timestep_accumulator.sv
`default_nettype none

// Channel   Direction  Payload                                         Handshake
// req_ch    in         op[1:0], value_ns[63:0] (signed)                valid/ready
// rsp_ch    out        ticks_granted[7:0], capped, alpha_q16[15:0],    valid/ready
//                      tick_total[47:0]
// csr_ch    in         index[0:0] (0 tick length, 1 tick cap), data    valid/ready
//
// An update or advance runs the one-bit-per-cycle restoring divider before the
// block is ready again: 64 quotient steps, then ALPHA_BITS fraction steps.
// Reset operations and the first update after reset skip the divider and go
// straight from the PREP state to the PUSH state.
// Reset is synchronous; configuration returns to a 16666667 ns tick and a cap of 5.
// A result waits in an output register, so a stalled response only holds the
// block when the next result is ready to be written.

module fixed_timestep_accumulator
   import ftacc_pkg::*;
#(
   parameter int unsigned ALPHA_BITS = 16
) (
   input wire         clock,
   input wire         reset,
   ftacc_req_if.sink  req_ch,
   ftacc_rsp_if.source rsp_ch,
   ftacc_csr_if.sink  csr_ch
);

   cmd_type    cmd;
   status_type status;

   // Configuration writes are always taken; they land in the datapath registers.
   assign csr_ch.ready = 1'b1;

   // The controller sequences one transaction at a time through the datapath.
   ftacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the timing state, the shared divider and the output register.
   ftacc_dp #(
      .ALPHA_BITS (ALPHA_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_ch.op),
      .req_value_ns      (req_ch.value_ns),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ticks_granted (rsp_ch.ticks_granted),
      .rsp_capped        (rsp_ch.capped),
      .rsp_alpha_q16     (rsp_ch.alpha_q16),
      .rsp_tick_total    (rsp_ch.tick_total)
   );

endmodule

`default_nettype wire

### rtl/core/ftacc_ctrl.sv
`default_nettype none

module ftacc_ctrl
   import ftacc_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.quick ? ST_PUSH : ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            if (status.q_last) state_in = ST_FSTART;
         end
         ST_FSTART: begin
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            if (status.f_last) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_PREP:   cmd.prep   = 1'b1;
         ST_SUM:    cmd.bank   = 1'b1;
         ST_QUOT:   cmd.qstep  = 1'b1;
         ST_FSTART: cmd.fstart = 1'b1;
         ST_FRAC:   cmd.fstep  = 1'b1;
         ST_PUSH:   cmd.push   = status.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/ftacc_dp.sv
`default_nettype none

module ftacc_dp
   import ftacc_pkg::*;
#(
   parameter int unsigned ALPHA_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  wire [OP_W-1:0]         req_op,
   input  wire [VALUE_W-1:0]      req_value_ns,
   input  wire                    csr_valid,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data,
   input  wire                    rsp_ready,
   output logic                   rsp_valid,
   output logic [CAP_W-1:0]       rsp_ticks_granted,
   output logic                   rsp_capped,
   output logic [ALPHA_W-1:0]     rsp_alpha_q16,
   output logic [TOTAL_W-1:0]     rsp_tick_total
);

   // Control and architectural state.
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic               started_ff, started_in;
   logic [TICK_W-1:0]  bank_ff, bank_in;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic               out_valid_ff, out_valid_in;

   // Working payload.
   op_type             op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] delta_ff, delta_in;
   logic [TICK_W:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0] dvd_ff, dvd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CAP_W-1:0]   n_ff, n_in;
   logic               flag_ff, flag_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   // Output register.
   logic [CAP_W-1:0]   o_ticks_ff, o_ticks_in;
   logic               o_capped_ff, o_capped_in;
   logic [ALPHA_W-1:0] o_alpha_ff, o_alpha_in;
   logic [TOTAL_W-1:0] o_total_ff, o_total_in;

   logic [TICK_W-1:0]  tick_eff;
   logic [CAP_W-1:0]   cap_eff;
   logic [TICK_W:0]    rem_shift;
   logic               quot_bit;
   logic [TICK_W:0]    rem_sub;
   logic [VALUE_W:0]   sum_wide;
   logic               whole_big;

   assign tick_eff = (tick_ff == '0) ? TICK_RESET : tick_ff;
   assign cap_eff  = (cap_ff == '0) ? CAP_RESET : cap_ff;

   // One restoring division step, shared by the quotient and fraction phases.
   assign rem_shift = {rem_ff[TICK_W-1:0], cmd.qstep ? dvd_ff[VALUE_W-1] : 1'b0};
   assign quot_bit  = (rem_shift >= {1'b0, tick_eff});
   assign rem_sub   = rem_shift - {1'b0, tick_eff};

   assign sum_wide  = {{(VALUE_W-TICK_W+1){1'b0}}, bank_ff} + {1'b0, delta_ff};
   assign whole_big = (|dvd_ff[VALUE_W-1:CAP_W]) || (dvd_ff[CAP_W-1:0] > cap_eff);

   assign status.quick    = (op_ff == OP_RESET_IDLE) || (op_ff == OP_RESET_AT) ||
                            ((op_ff == OP_UPDATE) && !started_ff);
   assign status.q_last   = (step_ff == STEP_W'(QUOT_STEPS - 1));
   assign status.f_last   = (step_ff == STEP_W'(ALPHA_BITS - 1));
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      tick_in      = tick_ff;
      cap_in       = cap_ff;
      last_in      = last_ff;
      started_in   = started_ff;
      bank_in      = bank_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      op_in        = op_ff;
      val_in       = val_ff;
      delta_in     = delta_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      flag_in      = flag_ff;
      alpha_in     = alpha_ff;
      o_ticks_in   = o_ticks_ff;
      o_capped_in  = o_capped_ff;
      o_alpha_in   = o_alpha_ff;
      o_total_in   = o_total_ff;

      if (csr_valid) begin
         if (csr_index == CSR_TICK_LENGTH) tick_in = csr_data[TICK_W-1:0];
         if (csr_index == CSR_TICK_CAP)    cap_in  = csr_data[CAP_W-1:0];
      end

      if (cmd.take) begin
         op_in  = op_type'(req_op);
         val_in = req_value_ns;
      end

      if (cmd.prep) begin
         n_in     = '0;
         flag_in  = 1'b0;
         alpha_in = '0;
         case (op_ff)
            OP_UPDATE: begin
               last_in    = val_ff;
               started_in = 1'b1;
               delta_in   = ($signed(val_ff) >= $signed(last_ff)) ? (val_ff - last_ff) : '0;
            end
            OP_ADVANCE: begin
               delta_in = val_ff[VALUE_W-1] ? '0 : val_ff;
            end
            OP_RESET_IDLE: begin
               last_in    = '0;
               started_in = 1'b0;
               bank_in    = '0;
               count_in   = '0;
            end
            OP_RESET_AT: begin
               last_in    = val_ff;
               started_in = 1'b1;
               bank_in    = '0;
               count_in   = '0;
            end
            default: begin
               delta_in = '0;
            end
         endcase
      end

      if (cmd.bank) begin
         dvd_in  = sum_wide[VALUE_W] ? '1 : sum_wide[VALUE_W-1:0];
         rem_in  = '0;
         step_in = '0;
      end

      if (cmd.qstep || cmd.fstep) begin
         rem_in  = quot_bit ? rem_sub : rem_shift;
         step_in = step_ff + 1'b1;
      end
      if (cmd.qstep) dvd_in = {dvd_ff[VALUE_W-2:0], quot_bit};
      if (cmd.fstep) alpha_in = {alpha_ff[ALPHA_W-2:0], quot_bit};

      if (cmd.fstart) begin
         n_in     = whole_big ? cap_eff : dvd_ff[CAP_W-1:0];
         flag_in  = whole_big;
         bank_in  = rem_ff[TICK_W-1:0];
         count_in = count_ff + TOTAL_W'(n_in);
         alpha_in = '0;
         step_in  = '0;
      end

      if (cmd.push) begin
         out_valid_in = 1'b1;
         o_ticks_in   = n_ff;
         o_capped_in  = flag_ff;
         o_alpha_in   = alpha_ff;
         o_total_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= TICK_RESET;
         cap_ff       <= CAP_RESET;
         last_ff      <= '0;
         started_ff   <= 1'b0;
         bank_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         cap_ff       <= cap_in;
         last_ff      <= last_in;
         started_ff   <= started_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      delta_ff    <= delta_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      step_ff     <= step_in;
      n_ff        <= n_in;
      flag_ff     <= flag_in;
      alpha_ff    <= alpha_in;
      o_ticks_ff  <= o_ticks_in;
      o_capped_ff <= o_capped_in;
      o_alpha_ff  <= o_alpha_in;
      o_total_ff  <= o_total_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ticks_granted = o_ticks_ff;
   assign rsp_capped        = o_capped_ff;
   assign rsp_alpha_q16     = o_alpha_ff;
   assign rsp_tick_total    = o_total_ff;

endmodule

`default_nettype wire
